### sv/cut_grid_pass_counter_macros.svh
// Assertion macros shared by the counter RTL.
`ifndef CUT_GRID_PASS_COUNTER_MACROS_SVH
`define CUT_GRID_PASS_COUNTER_MACROS_SVH

// Property checked on clk_i, off while rst_ni is low.
`define CGPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen on clk_i.
`define CGPC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/cgpc_pkg.sv
// Shared constants, types and helper functions of the cut grid counter.
package cgpc_pkg;

  localparam int N_DETA     = 5;
  localparam int N_DPHI     = 5;
  localparam int N_HOE      = 5;
  localparam int N_S9       = 3;
  localparam int N_EOPMIN   = 6;
  localparam int N_SEEMIN   = 4;
  localparam int N_SEEMAX   = 4;
  localparam int N_SAMPLES  = 3;
  localparam int COUNT_BITS = 24;

  localparam int GRID      = N_DETA * N_DPHI * N_HOE * N_S9 * N_EOPMIN * N_SEEMIN * N_SEEMAX;
  localparam int MEM_DEPTH = N_SAMPLES * GRID;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int SAMP_W    = (N_SAMPLES > 1) ? $clog2(N_SAMPLES) : 1;
  localparam int FW        = 44;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;

  localparam int DETA_W = (N_DETA > 1) ? $clog2(N_DETA) : 1;
  localparam int DPHI_W = (N_DPHI > 1) ? $clog2(N_DPHI) : 1;
  localparam int HOE_W  = (N_HOE > 1) ? $clog2(N_HOE) : 1;
  localparam int S9_W   = 2;
  localparam int EOP_W  = (N_EOPMIN > 1) ? $clog2(N_EOPMIN) : 1;
  localparam int SEE_W  = 2;

  localparam int DPHI_START[4]   = '{2, 2, 25, 25};
  localparam int DPHI_STEP[4]    = '{3, 3, 10, 10};
  localparam int EOPMAX_START[4] = '{1900, 1900, 999000, 999000};
  localparam int SEEMIN_START[4] = '{0, 0, 0, 2};
  localparam int SEEMAX_START[4] = '{7, 25, 7, 25};

  localparam logic [2:0] CLASS_NONE = 3'd4;

  typedef enum logic [1:0] {
    ACT_EVENT    = 2'd0,
    ACT_RD_BIN   = 2'd1,
    ACT_RD_CLASS = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    JOB_SCAN     = 2'd0,
    JOB_ZERO     = 2'd1,
    JOB_RD_BIN   = 2'd2,
    JOB_RD_CLASS = 2'd3
  } job_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_RDWAIT
  } state_e;

  typedef logic signed [FW-1:0] feat_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    job_e              job;
    logic [1:0]        sample;
    logic [1:0]        cls;
    logic [ADDR_W-1:0] addr;
    feat_t             deta;
    feat_t             dphi;
    feat_t             hoe;
    feat_t             s9;
    feat_t             eop;
    feat_t             see;
  } job_t;

  localparam count_t COUNT_MAX = '1;

  function automatic logic [2:0] map_class(input logic [7:0] code);
    logic [2:0] c;
    c = CLASS_NONE;
    if (code == 8'd0) c = 3'd0;
    else if (code == 8'd100) c = 3'd1;
    else if (code >= 8'd30 && code < 8'd40) c = 3'd2;
    else if (code >= 8'd130 && code < 8'd140) c = 3'd3;
    return c;
  endfunction

  // 1000 * x as shifts and subtracts
  function automatic feat_t scale1000(input logic signed [32:0] x);
    feat_t sx;
    sx = {{(FW-33){x[32]}}, x};
    return (sx <<< 10) - (sx <<< 4) - (sx <<< 3);
  endfunction

  // cut of m thousandths in the scaled domain: m * 2^20
  function automatic feat_t milli_thr(input int m);
    longint lm;
    lm = longint'(m) <<< 20;
    return feat_t'(lm);
  endfunction

  function automatic count_t sat_inc(input count_t c);
    return (c == COUNT_MAX) ? c : c + count_t'(1);
  endfunction

endpackage

### sv/cut_grid_pass_counter.sv
// Top level of the cut grid pass counter.
// An event of the configured class sweeps every cut combination (36000) through
// a read-modify-write of the single counter memory, one bin per cycle; other
// events and reads are answered without a sweep.
// After reset a clearing pass writes zero to all 108000 counters, one per
// cycle; commands are queued (two deep) but not executed until it is done.
// Each result shows on done_o for one cycle and cannot be held off.
// wanted_class must only be written while no command is pending.
module cut_grid_pass_counter import cgpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic         [1:0]  cfg_wdata_i,
  input  logic         [1:0]  action_i,
  input  logic         [1:0]  sample_i,
  input  logic         [7:0]  class_code_i,
  input  logic signed  [31:0] delta_eta_i,
  input  logic signed  [31:0] delta_phi_i,
  input  logic signed  [31:0] h_over_e_i,
  input  logic signed  [31:0] s9_over_s25_i,
  input  logic signed  [31:0] e_over_pout_i,
  input  logic signed  [31:0] sigma_ee_i,
  input  logic         [15:0] bin_index_i,
  output logic                done_o,
  output logic                class_match_o,
  output logic         [23:0] count_value_o
);

  logic [1:0] wanted_class_q;
  job_t       front_job;
  job_t       head_job;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       push;
  count_t     count_value;

  assign busy          = q_full;
  assign push          = start && !q_full;
  assign count_value_o = 24'(count_value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wanted_class_q <= '0;
    else if (cfg_we_i) wanted_class_q <= cfg_wdata_i;
  end

  cgpc_front u_front (
    .action_i       (action_i),
    .sample_i       (sample_i),
    .class_code_i   (class_code_i),
    .delta_eta_i    (delta_eta_i),
    .delta_phi_i    (delta_phi_i),
    .h_over_e_i     (h_over_e_i),
    .s9_over_s25_i  (s9_over_s25_i),
    .e_over_pout_i  (e_over_pout_i),
    .sigma_ee_i     (sigma_ee_i),
    .bin_index_i    (bin_index_i),
    .wanted_class_i (wanted_class_q),
    .job_o          (front_job)
  );

  cgpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .pop_i   (q_pop),
    .data_o  (head_job),
    .full_o  (q_full),
    .valid_o (q_valid)
  );

  cgpc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .job_i         (head_job),
    .pop_o         (q_pop),
    .done_o        (done_o),
    .class_match_o (class_match_o),
    .count_value_o (count_value)
  );

endmodule

### sv/cgpc_front.sv
// Front end: decodes a command into a job for the sweep engine.
module cgpc_front import cgpc_pkg::*; (
  input  logic         [1:0]  action_i,
  input  logic         [1:0]  sample_i,
  input  logic         [7:0]  class_code_i,
  input  logic signed  [31:0] delta_eta_i,
  input  logic signed  [31:0] delta_phi_i,
  input  logic signed  [31:0] h_over_e_i,
  input  logic signed  [31:0] s9_over_s25_i,
  input  logic signed  [31:0] e_over_pout_i,
  input  logic signed  [31:0] sigma_ee_i,
  input  logic         [15:0] bin_index_i,
  input  logic         [1:0]  wanted_class_i,
  output job_t                job_o
);

  logic                samp_ok;
  logic                bin_ok;
  logic [ADDR_W-1:0]   base;
  logic signed [32:0]  hoe_ext;
  logic signed [32:0]  hoe_abs;

  assign samp_ok = 32'(sample_i) < N_SAMPLES;
  assign bin_ok  = 32'(bin_index_i) < GRID;
  assign base    = ADDR_W'(sample_i) * ADDR_W'(GRID);
  assign hoe_ext = {h_over_e_i[31], h_over_e_i};
  assign hoe_abs = hoe_ext[32] ? -hoe_ext : hoe_ext;

  always_comb begin
    job_o.job    = JOB_ZERO;
    job_o.sample = sample_i;
    job_o.cls    = wanted_class_i;
    job_o.addr   = base;
    job_o.deta   = scale1000({delta_eta_i[31], delta_eta_i});
    job_o.dphi   = scale1000({delta_phi_i[31], delta_phi_i});
    job_o.hoe    = scale1000(hoe_abs);
    job_o.s9     = scale1000({s9_over_s25_i[31], s9_over_s25_i});
    job_o.eop    = scale1000({e_over_pout_i[31], e_over_pout_i});
    job_o.see    = scale1000({sigma_ee_i[31], sigma_ee_i});
    case (action_e'(action_i))
      ACT_EVENT: begin
        if (samp_ok && map_class(class_code_i) == {1'b0, wanted_class_i}) job_o.job = JOB_SCAN;
      end
      ACT_RD_BIN: begin
        if (samp_ok && bin_ok) begin
          job_o.job  = JOB_RD_BIN;
          job_o.addr = base + ADDR_W'(bin_index_i);
        end
      end
      ACT_RD_CLASS: begin
        if (samp_ok) job_o.job = JOB_RD_CLASS;
      end
      default: job_o.job = JOB_ZERO;
    endcase
  end

endmodule

### sv/cgpc_queue.sv
// Two-entry job queue between front end and sweep engine.
`include "cut_grid_pass_counter_macros.svh"
module cgpc_queue import cgpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  job_t  data_i,
  input  logic  pop_i,
  output job_t  data_o,
  output logic  full_o,
  output logic  valid_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = count_q == (QPTR_W+1)'(QDEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  `CGPC_ASSERT(a_count_bound, count_q <= (QPTR_W+1)'(QDEPTH), "queue over depth")
  `CGPC_NEVER(a_pop_empty, pop_i && !valid_o, "pop from empty queue")
  `CGPC_ASSERT(a_count_up, push_i && !pop_i |=> count_q == $past(count_q) + 1'b1, "count slip")

endmodule

### sv/cgpc_back.sv
// Sweep engine: counter memory, cut evaluation, read-modify-write and results.
`include "cut_grid_pass_counter_macros.svh"
module cgpc_back import cgpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  job_t         job_i,
  output logic         pop_o,
  output logic         done_o,
  output logic         class_match_o,
  output count_t       count_value_o
);

  state_e            state_q, state_d;
  job_t              job_q, job_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [DETA_W-1:0] da_q, da_d;
  logic [DPHI_W-1:0] db_q, db_d;
  logic [HOE_W-1:0]  dh_q, dh_d;
  logic [S9_W-1:0]   ds_q, ds_d;
  logic [EOP_W-1:0]  de_q, de_d;
  logic [SEE_W-1:0]  dn_q, dn_d;
  logic [SEE_W-1:0]  dx_q, dx_d;
  logic              rmw_valid_q, rmw_valid_d;
  logic [ADDR_W-1:0] rmw_addr_q;
  count_t            class_cnt_q [N_SAMPLES];
  logic              cls_inc;
  logic              done_q, done_d;
  logic              match_q, match_d;
  count_t            value_q, value_d;
  count_t            mem [MEM_DEPTH];
  count_t            rdata_q;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  count_t            wr_data;
  logic              pass;
  logic              last;
  logic              c1, c2, c3, c4, c5, c6;
  int                c;

  assign done_o        = done_q;
  assign class_match_o = match_q;
  assign count_value_o = value_q;
  assign c             = int'(job_q.cls);

  always_comb begin
    pass = (job_q.deta <= milli_thr(2 + int'(da_q)))
        && (job_q.dphi <= milli_thr(DPHI_START[c] + int'(db_q) * DPHI_STEP[c]))
        && (job_q.hoe  <= milli_thr(30 + int'(dh_q) * 10))
        && (job_q.s9   >= milli_thr(600 + int'(ds_q) * 100))
        && (job_q.eop  >= milli_thr(400 + int'(de_q) * 100))
        && (job_q.eop  <= milli_thr(EOPMAX_START[c]))
        && (job_q.see  >= milli_thr(SEEMIN_START[c] + int'(dn_q) * 3))
        && (job_q.see  <= milli_thr(SEEMAX_START[c] + int'(dx_q) * 3));
  end

  // odometer over the grid, last digit innermost
  always_comb begin
    c1 = dx_q == SEE_W'(N_SEEMAX - 1);
    c2 = c1 && dn_q == SEE_W'(N_SEEMIN - 1);
    c3 = c2 && de_q == EOP_W'(N_EOPMIN - 1);
    c4 = c3 && ds_q == S9_W'(N_S9 - 1);
    c5 = c4 && dh_q == HOE_W'(N_HOE - 1);
    c6 = c5 && db_q == DPHI_W'(N_DPHI - 1);
    last = c6 && da_q == DETA_W'(N_DETA - 1);
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    addr_d      = addr_q;
    da_d = da_q; db_d = db_q; dh_d = dh_q; ds_d = ds_q;
    de_d = de_q; dn_d = dn_q; dx_d = dx_q;
    rmw_valid_d = 1'b0;
    pop_o       = 1'b0;
    cls_inc     = 1'b0;
    done_d      = 1'b0;
    match_d     = 1'b0;
    value_d     = '0;
    rd_en       = 1'b0;
    rd_addr     = addr_q;
    wr_en       = rmw_valid_q;
    wr_addr     = rmw_addr_q;
    wr_data     = sat_inc(rdata_q);
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = addr_q;
        wr_data = '0;
        addr_d  = addr_q + 1'b1;
        if (addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          case (job_i.job)
            JOB_SCAN: begin
              cls_inc = 1'b1;
              addr_d  = job_i.addr;
              da_d = '0; db_d = '0; dh_d = '0; ds_d = '0;
              de_d = '0; dn_d = '0; dx_d = '0;
              state_d = ST_SCAN;
            end
            JOB_RD_BIN: begin
              rd_en   = 1'b1;
              rd_addr = job_i.addr;
              state_d = ST_RDWAIT;
            end
            JOB_RD_CLASS: begin
              done_d  = 1'b1;
              value_d = class_cnt_q[SAMP_W'(job_i.sample)];
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        rd_en       = 1'b1;
        rmw_valid_d = pass;
        addr_d      = addr_q + 1'b1;
        dx_d = c1 ? '0 : dx_q + 1'b1;
        if (c1) dn_d = c2 ? '0 : dn_q + 1'b1;
        if (c2) de_d = c3 ? '0 : de_q + 1'b1;
        if (c3) ds_d = c4 ? '0 : ds_q + 1'b1;
        if (c4) dh_d = c5 ? '0 : dh_q + 1'b1;
        if (c5) db_d = c6 ? '0 : db_q + 1'b1;
        if (c6) da_d = last ? '0 : da_q + 1'b1;
        if (last) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        done_d  = 1'b1;
        match_d = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RDWAIT: begin
        done_d  = 1'b1;
        value_d = rdata_q;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      rmw_valid_q <= 1'b0;
      done_q      <= 1'b0;
      for (int i = 0; i < N_SAMPLES; i++) class_cnt_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      rmw_valid_q <= rmw_valid_d;
      done_q      <= done_d;
      if (cls_inc) begin
        class_cnt_q[SAMP_W'(job_i.sample)] <= sat_inc(class_cnt_q[SAMP_W'(job_i.sample)]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    da_q <= da_d; db_q <= db_d; dh_q <= dh_d; ds_q <= ds_d;
    de_q <= de_d; dn_q <= dn_d; dx_q <= dx_d;
    rmw_addr_q <= addr_q;
    match_q    <= match_d;
    value_q    <= value_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  `CGPC_NEVER(a_no_result_clear, state_q == ST_CLEAR && done_q, "result during clear")
  `CGPC_ASSERT(a_rmw_from_scan, rmw_valid_q |-> $past(state_q) == ST_SCAN, "stray write")
  `CGPC_ASSERT(a_match_after_flush, done_q && match_q |-> $past(state_q) == ST_FLUSH,
    "match without sweep")

endmodule
